FILE: sv/min_heap_priority_queue_top_assert.svh
// Assertion macros used by the checker of the min-heap priority queue.
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("min-heap queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("min-heap queue check failed");

`endif

FILE: sv/mhpq_pkg.sv
// Package with the sizes, codes and shared types of the min-heap priority queue.
package mhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int KEY_BITS = 20;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = CNT_W + 1;
	localparam int CMD_W = 2;
	localparam int STAT_W = 2;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 2'd0,
		CMD_EXTRACT = 2'd1,
		CMD_PEEK    = 2'd2,
		CMD_CHANGE  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		key_t    result_key;
		status_t status;
		cnt_t    occupancy;
	} rsp_t;

	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		key_t wr_data;
	} ram_req_t;

endpackage

FILE: sv/mhpq_in_if.sv
// Command channel interface of the min-heap priority queue.
interface mhpq_in_if;
	logic                       valid;
	logic                       ready;
	logic [mhpq_pkg::CMD_W-1:0] command;
	mhpq_pkg::key_t             key_value;
	mhpq_pkg::key_t             new_key;

	modport source (output valid, command, key_value, new_key, input ready);
	modport sink (input valid, command, key_value, new_key, output ready);
endinterface

FILE: sv/mhpq_out_if.sv
// Result channel interface of the min-heap priority queue.
interface mhpq_out_if;
	logic                        valid;
	logic                        ready;
	mhpq_pkg::key_t              result_key;
	logic [mhpq_pkg::STAT_W-1:0] status;
	mhpq_pkg::cnt_t              occupancy;

	modport source (output valid, result_key, status, occupancy, input ready);
	modport sink (input valid, result_key, status, occupancy, output ready);
endinterface

FILE: sv/mhpq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mhpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: sv/mhpq_ctrl.sv
// Heap sequencer: search, sift up and sift down around one shared key comparator.
module mhpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	mhpq_in_if.sink            req,
	output mhpq_pkg::ram_req_t ram_req,
	input  mhpq_pkg::key_t     ram_rd_data,
	input  logic               rsp_free,
	output logic               rsp_valid,
	output mhpq_pkg::rsp_t     rsp_data
);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_EX_ROOT = 12'b0000_0000_0010,
		S_EX_LAST = 12'b0000_0000_0100,
		S_PK_ROOT = 12'b0000_0000_1000,
		S_SRCH    = 12'b0000_0001_0000,
		S_CHG_DIR = 12'b0000_0010_0000,
		S_UP      = 12'b0000_0100_0000,
		S_UP_CMP  = 12'b0000_1000_0000,
		S_DN      = 12'b0001_0000_0000,
		S_DN_L    = 12'b0010_0000_0000,
		S_DN_R    = 12'b0100_0000_0000,
		S_DONE    = 12'b1000_0000_0000
	} state_t;

	state_t              state_q, state_d;
	mhpq_pkg::cnt_t      count_q, count_d;
	mhpq_pkg::key_t      key_in_q, key_in_d;
	mhpq_pkg::key_t      nkey_q, nkey_d;
	mhpq_pkg::key_t      key_q, key_d;
	mhpq_pkg::idx_t      pos_q, pos_d;
	mhpq_pkg::cnt_t      srch_q, srch_d;
	mhpq_pkg::key_t      best_val_q, best_val_d;
	logic                best_left_q, best_left_d;
	mhpq_pkg::key_t      res_key_q, res_key_d;
	mhpq_pkg::status_t   status_q, status_d;

	mhpq_pkg::key_t      cmp_a, cmp_b;
	logic                cmp_lt, cmp_eq;
	mhpq_pkg::idx_t      parent_idx;
	mhpq_pkg::pos_t      left_pos, right_pos, count_ext;
	logic                left_in, right_in;
	mhpq_pkg::cnt_t      srch_nxt;

	always_comb begin
		case (state_q)
			S_SRCH: begin
				cmp_a = ram_rd_data;
				cmp_b = key_in_q;
			end
			S_CHG_DIR: begin
				cmp_a = nkey_q;
				cmp_b = key_in_q;
			end
			S_UP_CMP: begin
				cmp_a = key_q;
				cmp_b = ram_rd_data;
			end
			S_DN_L: begin
				cmp_a = ram_rd_data;
				cmp_b = key_q;
			end
			S_DN_R: begin
				cmp_a = ram_rd_data;
				cmp_b = best_val_q;
			end
			default: begin
				cmp_a = key_q;
				cmp_b = key_q;
			end
		endcase
	end

	assign cmp_lt = cmp_a < cmp_b;
	assign cmp_eq = cmp_a == cmp_b;

	assign parent_idx = mhpq_pkg::idx_t'(pos_q - 1'b1) >> 1;
	assign left_pos   = mhpq_pkg::pos_t'({pos_q, 1'b1});
	assign right_pos  = mhpq_pkg::pos_t'(left_pos + 1'b1);
	assign count_ext  = mhpq_pkg::pos_t'(count_q);
	assign left_in    = left_pos < count_ext;
	assign right_in   = right_pos < count_ext;
	assign srch_nxt   = mhpq_pkg::cnt_t'(srch_q + 1'b1);

	assign req.ready          = state_q == S_IDLE;
	assign rsp_valid          = state_q == S_DONE;
	assign rsp_data.result_key = res_key_q;
	assign rsp_data.status     = status_q;
	assign rsp_data.occupancy  = count_q;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		key_in_d    = key_in_q;
		nkey_d      = nkey_q;
		key_d       = key_q;
		pos_d       = pos_q;
		srch_d      = srch_q;
		best_val_d  = best_val_q;
		best_left_d = best_left_q;
		res_key_d   = res_key_q;
		status_d    = status_q;
		ram_req     = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					key_in_d  = req.key_value;
					nkey_d    = req.new_key;
					res_key_d = '0;
					status_d  = mhpq_pkg::ST_OK;
					srch_d    = '0;
					unique case (mhpq_pkg::cmd_t'(req.command))
						mhpq_pkg::CMD_INSERT: begin
							if (count_q == mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY)) begin
								status_d = mhpq_pkg::ST_FULL;
								state_d  = S_DONE;
							end else begin
								key_d   = req.key_value;
								pos_d   = count_q[mhpq_pkg::IDX_W-1:0];
								count_d = mhpq_pkg::cnt_t'(count_q + 1'b1);
								state_d = S_UP;
							end
						end
						mhpq_pkg::CMD_EXTRACT: begin
							if (count_q == '0) begin
								status_d = mhpq_pkg::ST_EMPTY;
								state_d  = S_DONE;
							end else begin
								ram_req.rd_en = 1'b1;
								state_d       = S_EX_ROOT;
							end
						end
						mhpq_pkg::CMD_PEEK: begin
							if (count_q == '0) begin
								status_d = mhpq_pkg::ST_EMPTY;
								state_d  = S_DONE;
							end else begin
								ram_req.rd_en = 1'b1;
								state_d       = S_PK_ROOT;
							end
						end
						mhpq_pkg::CMD_CHANGE: begin
							if (count_q == '0) begin
								status_d = mhpq_pkg::ST_EMPTY;
								state_d  = S_DONE;
							end else begin
								ram_req.rd_en = 1'b1;
								state_d       = S_SRCH;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_EX_ROOT: begin
				res_key_d       = ram_rd_data;
				count_d         = mhpq_pkg::cnt_t'(count_q - 1'b1);
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = mhpq_pkg::idx_t'(count_q - 1'b1);
				state_d         = S_EX_LAST;
			end
			S_EX_LAST: begin
				key_d   = ram_rd_data;
				pos_d   = '0;
				state_d = S_DN;
			end
			S_PK_ROOT: begin
				res_key_d = ram_rd_data;
				state_d   = S_DONE;
			end
			S_SRCH: begin
				if (cmp_eq) begin
					pos_d   = srch_q[mhpq_pkg::IDX_W-1:0];
					state_d = S_CHG_DIR;
				end else if (srch_nxt == count_q) begin
					status_d = mhpq_pkg::ST_NOT_FOUND;
					state_d  = S_DONE;
				end else begin
					srch_d          = srch_nxt;
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = srch_nxt[mhpq_pkg::IDX_W-1:0];
				end
			end
			S_CHG_DIR: begin
				key_d = nkey_q;
				if (cmp_lt) begin
					state_d = S_UP;
				end else if (cmp_eq) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DN;
				end
			end
			S_UP: begin
				if (pos_q == '0) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = pos_q;
					ram_req.wr_data = key_q;
					state_d         = S_DONE;
				end else begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = parent_idx;
					state_d         = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = pos_q;
				if (cmp_lt) begin
					ram_req.wr_data = ram_rd_data;
					pos_d           = parent_idx;
					state_d         = S_UP;
				end else begin
					ram_req.wr_data = key_q;
					state_d         = S_DONE;
				end
			end
			S_DN: begin
				if (left_in) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = left_pos[mhpq_pkg::IDX_W-1:0];
					state_d         = S_DN_L;
				end else begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = pos_q;
					ram_req.wr_data = key_q;
					state_d         = S_DONE;
				end
			end
			S_DN_L: begin
				if (right_in) begin
					best_val_d      = cmp_lt ? ram_rd_data : key_q;
					best_left_d     = cmp_lt;
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = right_pos[mhpq_pkg::IDX_W-1:0];
					state_d         = S_DN_R;
				end else begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_addr = pos_q;
					if (cmp_lt) begin
						ram_req.wr_data = ram_rd_data;
						pos_d           = left_pos[mhpq_pkg::IDX_W-1:0];
						state_d         = S_DN;
					end else begin
						ram_req.wr_data = key_q;
						state_d         = S_DONE;
					end
				end
			end
			S_DN_R: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = pos_q;
				if (cmp_lt) begin
					ram_req.wr_data = ram_rd_data;
					pos_d           = right_pos[mhpq_pkg::IDX_W-1:0];
					state_d         = S_DN;
				end else if (best_left_q) begin
					ram_req.wr_data = best_val_q;
					pos_d           = left_pos[mhpq_pkg::IDX_W-1:0];
					state_d         = S_DN;
				end else begin
					ram_req.wr_data = key_q;
					state_d         = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		key_in_q    <= key_in_d;
		nkey_q      <= nkey_d;
		key_q       <= key_d;
		pos_q       <= pos_d;
		srch_q      <= srch_d;
		best_val_q  <= best_val_d;
		best_left_q <= best_left_d;
		res_key_q   <= res_key_d;
		status_q    <= status_d;
	end

endmodule

FILE: sv/min_heap_priority_queue_top.sv
// Binary min-heap priority queue holding up to CAPACITY keys in one RAM; the smallest key
// is served first. Commands are taken one at a time and the command port stays not ready
// until the item's result has been handed to the result register. All work goes through the
// single read port of the heap RAM, one read per step, and one key comparator. Peek reads the
// root; insert sifts the new key up level by level; extract reads the root and the last entry
// and sifts the moved key down; change searches the entries in storage order and then sifts
// the changed key up or down as needed; with 1024 keys a sift spans at most 10 levels.
// Results wait in an output register, so the next command is accepted while one is pending.
module min_heap_priority_queue_top (
	input  logic       clk,
	input  logic       arst_n,
	mhpq_in_if.sink    req,
	mhpq_out_if.source rsp
);

	mhpq_pkg::ram_req_t ram_req;
	mhpq_pkg::key_t     ram_rd_data;
	logic               done_valid;
	mhpq_pkg::rsp_t     done_data;
	logic               rsp_free;
	logic               rsp_valid_q;
	mhpq_pkg::rsp_t     rsp_data_q;

	mhpq_ram #(
		.WIDTH(mhpq_pkg::KEY_BITS),
		.DEPTH(mhpq_pkg::CAPACITY)
	) u_heap_ram (
		.clk(clk),
		.wr_en(ram_req.wr_en),
		.wr_addr(ram_req.wr_addr),
		.wr_data(ram_req.wr_data),
		.rd_en(ram_req.rd_en),
		.rd_addr(ram_req.rd_addr),
		.rd_data(ram_rd_data)
	);

	mhpq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.ram_req(ram_req),
		.ram_rd_data(ram_rd_data),
		.rsp_free(rsp_free),
		.rsp_valid(done_valid),
		.rsp_data(done_data)
	);

	assign rsp_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid_q <= done_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (done_valid && rsp_free) begin
			rsp_data_q <= done_data;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.result_key = rsp_data_q.result_key;
	assign rsp.status     = rsp_data_q.status;
	assign rsp.occupancy  = rsp_data_q.occupancy;

endmodule

FILE: sv/mhpq_checker.sv
// Port-level checker for the min-heap priority queue, bound to the top level.
`include "min_heap_priority_queue_top_assert.svh"

module mhpq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input mhpq_pkg::key_t              rsp_result_key,
	input logic [mhpq_pkg::STAT_W-1:0] rsp_status,
	input mhpq_pkg::cnt_t              rsp_occupancy
);

	logic rsp_empty;
	logic rsp_failed;
	logic occ_in_range;

	assign rsp_empty    = rsp_status == mhpq_pkg::ST_EMPTY;
	assign rsp_failed   = rsp_status != mhpq_pkg::ST_OK;
	assign occ_in_range = rsp_occupancy <= mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY);

	`MHPQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`MHPQ_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)
	`MHPQ_ASSERT_NOW(a_occ_bound, clk, arst_n, rsp_valid, occ_in_range)
	`MHPQ_ASSERT_NOW(a_empty_occ, clk, arst_n, rsp_valid && rsp_empty, rsp_occupancy == '0)
	`MHPQ_ASSERT_NOW(a_fail_zero, clk, arst_n, rsp_valid && rsp_failed, rsp_result_key == '0)

endmodule

bind min_heap_priority_queue_top mhpq_checker u_mhpq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_result_key(rsp.result_key),
	.rsp_status(rsp.status),
	.rsp_occupancy(rsp.occupancy)
);
